// ===== hdl/datagram_header_parser_loss_counter_macros.svh =====
// assertion macros shared by the datagram header parser files
`ifndef DATAGRAM_HEADER_PARSER_LOSS_COUNTER_MACROS_SVH
`define DATAGRAM_HEADER_PARSER_LOSS_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define DHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define DHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/dhp_pkg.sv =====
// shared types and constants of the datagram header parser
`timescale 1ns / 1ps

package dhp_pkg;

    // verdict codes
    localparam logic [1:0] VERDICT_ACCEPTED  = 2'd0;
    localparam logic [1:0] VERDICT_SHORT     = 2'd1;
    localparam logic [1:0] VERDICT_BAD_MAGIC = 2'd2;
    localparam logic [1:0] VERDICT_TRUNCATED = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_PCM_CODE   = 1'b1;
    localparam int CFG_DATA_W = 32;

    // header layout, byte offsets within the datagram
    localparam int OFF_MAGIC    = 0;
    localparam int OFF_CODEC    = 4;
    localparam int OFF_RATE     = 5;
    localparam int OFF_CHANNELS = 8;
    localparam int OFF_LENGTH   = 9;
    localparam int HEADER_BYTES = 11;
    localparam int OFF_SEQUENCE = 11;
    localparam int SEQUENCE_END = 13;
    localparam int MIN_SEQ_LENGTH = 2;

    // one queued request from front to back
    typedef struct packed {
        logic        is_restart;
        logic [1:0]  verdict;
        logic [7:0]  codec;
        logic [23:0] rate;
        logic [7:0]  channels;
        logic [15:0] length;
        logic [15:0] sequence_no;
        logic        track;
    } dhp_entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } dhp_q_status_t;

endpackage

// ===== hdl/dhp_in_if.sv =====
// input channel: one datagram byte or restart command per request
`timescale 1ns / 1ps

interface dhp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output command, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input last_byte,
                    output ready);
endinterface

// ===== hdl/dhp_out_if.sv =====
// output channel: one verdict and header summary per datagram
`timescale 1ns / 1ps

interface dhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [7:0]  codec_id;
    logic [23:0] sample_rate;
    logic [7:0]  channel_count;
    logic [15:0] payload_length;
    logic [31:0] lost_packets;

    modport source (output valid, output verdict, output codec_id, output sample_rate,
                    output channel_count, output payload_length, output lost_packets,
                    input ready);
    modport sink   (input valid, input verdict, input codec_id, input sample_rate,
                    input channel_count, input payload_length, input lost_packets,
                    output ready);
endinterface

// ===== hdl/dhp_front.sv =====
// front end: byte capture, header fields and verdict per datagram
`timescale 1ns / 1ps
`include "datagram_header_parser_loss_counter_macros.svh"

module dhp_front
    import dhp_pkg::*;
#(
    parameter int MAX_DATAGRAM = 1600
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dhp_in_if.sink               in_ch,
    input  dhp_q_status_t        q_status,
    output logic                 push,
    output dhp_entry_t           push_entry
);

    localparam int CNT_W = $clog2(MAX_DATAGRAM + 1);

    logic [31:0]      expected_magic_reg;
    logic [7:0]       raw_pcm_code_reg;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [31:0]      magic_reg, magic_next;
    logic [7:0]       codec_reg, codec_next;
    logic [23:0]      rate_reg, rate_next;
    logic [7:0]       channels_reg, channels_next;
    logic [15:0]      length_reg, length_next;
    logic [15:0]      seq_reg, seq_next;

    logic             accept;
    logic             take_byte;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] rel_rate, rel_length, rel_seq;
    logic [CNT_W-1:0] count_after;
    logic [16:0]      needed;
    logic [1:0]       verdict;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pos         = byte_count_reg;
    assign take_byte   = accept && !in_ch.command && (byte_count_reg < CNT_W'(MAX_DATAGRAM));
    assign rel_rate    = pos - CNT_W'(OFF_RATE);
    assign rel_length  = pos - CNT_W'(OFF_LENGTH);
    assign rel_seq     = pos - CNT_W'(OFF_SEQUENCE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_magic_reg <= '0;
            raw_pcm_code_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_MAGIC: expected_magic_reg <= cfg_data;
                CFG_RAW_PCM_CODE:   raw_pcm_code_reg   <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // merge the current byte into the header fields
    always_comb
    begin
        magic_next    = magic_reg;
        codec_next    = codec_reg;
        rate_next     = rate_reg;
        channels_next = channels_reg;
        length_next   = length_reg;
        seq_next      = seq_reg;
        if (take_byte)
        begin
            case (pos) inside
                [OFF_MAGIC:OFF_CODEC-1]:       magic_next[8*pos[1:0] +: 8] = in_ch.data_byte;
                OFF_CODEC:                     codec_next = in_ch.data_byte;
                [OFF_RATE:OFF_CHANNELS-1]:     rate_next[8*rel_rate[1:0] +: 8] = in_ch.data_byte;
                OFF_CHANNELS:                  channels_next = in_ch.data_byte;
                [OFF_LENGTH:HEADER_BYTES-1]:   length_next[8*rel_length[0] +: 8] = in_ch.data_byte;
                [OFF_SEQUENCE:SEQUENCE_END-1]: seq_next[8*rel_seq[0] +: 8] = in_ch.data_byte;
                default:                       ;
            endcase
        end
    end

    // verdict from the fields as they stand after this byte
    assign count_after = byte_count_reg + CNT_W'(take_byte);
    assign needed      = 17'(HEADER_BYTES) + {1'b0, length_next};

    always_comb
    begin
        if (count_after < CNT_W'(HEADER_BYTES))
            verdict = VERDICT_SHORT;
        else if (magic_next != expected_magic_reg)
            verdict = VERDICT_BAD_MAGIC;
        else if (needed > 17'(count_after))
            verdict = VERDICT_TRUNCATED;
        else
            verdict = VERDICT_ACCEPTED;
    end

    // queue request: restart command or end of datagram
    assign push = accept && (in_ch.command || in_ch.last_byte);

    always_comb
    begin
        push_entry.is_restart  = in_ch.command;
        push_entry.verdict     = verdict;
        push_entry.codec       = codec_next;
        push_entry.rate        = rate_next;
        push_entry.channels    = channels_next;
        push_entry.length      = length_next;
        push_entry.sequence_no = seq_next;
        push_entry.track       = !in_ch.command && (verdict == VERDICT_ACCEPTED)
                                 && (codec_next == raw_pcm_code_reg)
                                 && (length_next >= 16'(MIN_SEQ_LENGTH));
    end

    // per-datagram capture, cleared when the datagram ends
    assign byte_count_next = count_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            magic_reg      <= '0;
            codec_reg      <= '0;
            rate_reg       <= '0;
            channels_reg   <= '0;
            length_reg     <= '0;
            seq_reg        <= '0;
        end
        else if (accept && !in_ch.command)
        begin
            if (in_ch.last_byte)
            begin
                byte_count_reg <= '0;
                magic_reg      <= '0;
                codec_reg      <= '0;
                rate_reg       <= '0;
                channels_reg   <= '0;
                length_reg     <= '0;
                seq_reg        <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                magic_reg      <= magic_next;
                codec_reg      <= codec_next;
                rate_reg       <= rate_next;
                channels_reg   <= channels_next;
                length_reg     <= length_next;
                seq_reg        <= seq_next;
            end
        end
    end

    `DHP_ASSERT_NXT(a_count_clears, clk, rst_n, accept && !in_ch.command && in_ch.last_byte, byte_count_reg == '0, "byte count not cleared after last byte")
    `DHP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, byte_count_reg <= CNT_W'(MAX_DATAGRAM), "byte count beyond datagram limit")

endmodule

// ===== hdl/dhp_queue.sv =====
// short fifo of classified requests between front and back
`timescale 1ns / 1ps
`include "datagram_header_parser_loss_counter_macros.svh"

module dhp_queue
    import dhp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dhp_entry_t    push_entry,
    input  logic          pop,
    output dhp_entry_t    head_entry,
    output dhp_q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dhp_entry_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_entry   = slots[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `DHP_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !status.full, "push into full queue")
    `DHP_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !status.empty, "pop from empty queue")

endmodule

// ===== hdl/dhp_back.sv =====
// back end: sequence gap loss tracking and result register
`timescale 1ns / 1ps
`include "datagram_header_parser_loss_counter_macros.svh"

module dhp_back
    import dhp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  dhp_entry_t    head_entry,
    input  dhp_q_status_t q_status,
    output logic          pop,
    dhp_out_if.source     out_ch
);

    logic        out_valid_reg;
    logic [1:0]  verdict_reg;
    logic [7:0]  codec_reg;
    logic [23:0] rate_reg;
    logic [7:0]  channels_reg;
    logic [15:0] length_reg;
    logic [31:0] lost_reg;

    logic        seen_reg, seen_next;
    logic [15:0] prev_seq_reg, prev_seq_next;
    logic [31:0] loss_total_reg, loss_total_next;
    logic [15:0] gap;
    logic        out_free;
    logic        pop_datagram;

    // restart requests drain at once, datagrams need a free result slot
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign pop          = !q_status.empty && (head_entry.is_restart || out_free);
    assign pop_datagram = pop && !head_entry.is_restart;

    // loss update for the datagram at the head
    assign gap = head_entry.sequence_no - prev_seq_reg;

    always_comb
    begin
        seen_next       = seen_reg;
        prev_seq_next   = prev_seq_reg;
        loss_total_next = loss_total_reg;
        if (pop && head_entry.is_restart)
            seen_next = 1'b0;
        else if (pop_datagram && head_entry.track)
        begin
            if (seen_reg && (gap > 16'd1))
                loss_total_next = loss_total_reg + 32'(gap - 16'd1);
            prev_seq_next = head_entry.sequence_no;
            seen_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_seq_reg   <= '0;
            loss_total_reg <= '0;
        end
        else
        begin
            seen_reg       <= seen_next;
            prev_seq_reg   <= prev_seq_next;
            loss_total_reg <= loss_total_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop_datagram)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop_datagram)
        begin
            verdict_reg  <= head_entry.verdict;
            codec_reg    <= head_entry.codec;
            rate_reg     <= head_entry.rate;
            channels_reg <= head_entry.channels;
            length_reg   <= head_entry.length;
            lost_reg     <= loss_total_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.verdict        = verdict_reg;
    assign out_ch.codec_id       = codec_reg;
    assign out_ch.sample_rate    = rate_reg;
    assign out_ch.channel_count  = channels_reg;
    assign out_ch.payload_length = length_reg;
    assign out_ch.lost_packets   = lost_reg;

    `DHP_ASSERT_NXT(a_loss_hold, clk, rst_n, !(pop_datagram && head_entry.track), $stable(loss_total_reg), "loss total moved without a tracked datagram")
    `DHP_ASSERT_NXT(a_restart_clears, clk, rst_n, pop && head_entry.is_restart, !seen_reg, "restart did not clear sequence seen")

endmodule

// ===== hdl/datagram_header_parser_loss_counter.sv =====
// top level of the datagram header parser with sequence loss counter
//
// in_ch carries one request per cycle while the queue has room: a datagram
// byte (command 0, last_byte marks the final byte) or a restart (command 1)
// that clears the sequence-seen flag. Bytes past MAX_DATAGRAM are dropped
// but a last_byte mark on them still ends the datagram.
// out_ch carries one result per datagram: verdict, header fields and the
// running lost-packet count. Restarts and non-final bytes give no result.
// Throughput is one request per cycle while the queue has room; the front
// classifies each byte combinationally and the back retires one queued
// request per cycle, holding a datagram until the result register is free.
// The final byte's result passes the request queue, then the result register.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the expected
// magic word and the raw PCM codec code; write it only while idle.
// When out_ch stalls, results wait in the register and the queue fills;
// in_ch.ready drops only once the queue is full.
// Reset clears the captures, the loss state, the queue and both registers.
`timescale 1ns / 1ps

module datagram_header_parser_loss_counter
    import dhp_pkg::*;
#(
    parameter int MAX_DATAGRAM = 1600,
    parameter int QUEUE_DEPTH  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dhp_in_if.sink                in_ch,
    dhp_out_if.source             out_ch
);

    logic          push, pop;
    dhp_entry_t    push_entry, head_entry;
    dhp_q_status_t q_status;

    dhp_front #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    dhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    dhp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/dhp_verdict_checker.sv =====
// checker that predicts datagram verdicts and loss counts and compares the result channel
`timescale 1ns / 1ps

module dhp_verdict_checker
    import dhp_pkg::*;
#(
    parameter int MAX_BYTES = 1600
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dhp_in_if                     in_ch,
    dhp_out_if                    out_ch,
    output int                    fail_count,
    output int                    pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [7:0]  codec;
        logic [23:0] rate;
        logic [7:0]  chans;
        logic [15:0] len;
        logic [31:0] lost;
    } verdict_rec_t;

    // mirrored registers
    logic [31:0] magic_reg;
    logic [7:0]  pcm_reg;

    // per-datagram captures
    logic [10:0] byte_cnt;
    logic [31:0] magic_acc;
    logic [7:0]  codec_acc;
    logic [23:0] rate_acc;
    logic [7:0]  chan_acc;
    logic [15:0] len_acc;
    logic [15:0] seq_acc;

    // loss tracking across datagrams
    logic [15:0] last_seq;
    logic        seq_valid;
    logic [31:0] lost_total;

    verdict_rec_t expected_verdicts[$];
    verdict_rec_t want;
    verdict_rec_t got;
    verdict_rec_t fresh;
    int           mismatches;

    function automatic void clear_captures();
        byte_cnt  = '0;
        magic_acc = '0;
        codec_acc = '0;
        rate_acc  = '0;
        chan_acc  = '0;
        len_acc   = '0;
        seq_acc   = '0;
    endfunction

    // advance the model by one request, returns 1 when a datagram ends
    function automatic bit parse_request(input logic is_restart, input logic [7:0] b,
                                         input logic is_last, output verdict_rec_t rec);
        int          pos;
        logic [15:0] gap;
        rec = '0;
        if (is_restart) begin
            seq_valid = 1'b0;
            return 1'b0;
        end

        // bytes past the size limit are neither stored nor counted
        if (int'(byte_cnt) < MAX_BYTES) begin
            pos = int'(byte_cnt);
            if (pos < OFF_CODEC)
                magic_acc[8*(pos-OFF_MAGIC) +: 8] = b;
            else if (pos == OFF_CODEC)
                codec_acc = b;
            else if (pos < OFF_CHANNELS)
                rate_acc[8*(pos-OFF_RATE) +: 8] = b;
            else if (pos == OFF_CHANNELS)
                chan_acc = b;
            else if (pos < HEADER_BYTES)
                len_acc[8*(pos-OFF_LENGTH) +: 8] = b;
            else if (pos < SEQUENCE_END)
                seq_acc[8*(pos-OFF_SEQUENCE) +: 8] = b;
            byte_cnt = byte_cnt + 11'd1;
        end

        if (!is_last)
            return 1'b0;

        if (int'(byte_cnt) < HEADER_BYTES)
            rec.verdict = VERDICT_SHORT;
        else if (magic_acc != magic_reg)
            rec.verdict = VERDICT_BAD_MAGIC;
        else if (HEADER_BYTES + int'(len_acc) > int'(byte_cnt))
            rec.verdict = VERDICT_TRUNCATED;
        else
            rec.verdict = VERDICT_ACCEPTED;

        // sequence gap on accepted raw pcm with room for a sequence number
        if (rec.verdict == VERDICT_ACCEPTED && codec_acc == pcm_reg
                && int'(len_acc) >= MIN_SEQ_LENGTH) begin
            gap = seq_acc - last_seq;
            if (seq_valid && gap > 16'd1)
                lost_total = lost_total + {16'd0, gap - 16'd1};
            last_seq  = seq_acc;
            seq_valid = 1'b1;
        end

        rec.codec = codec_acc;
        rec.rate  = rate_acc;
        rec.chans = chan_acc;
        rec.len   = len_acc;
        rec.lost  = lost_total;
        clear_captures();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg  = '0;
            pcm_reg    = '0;
            clear_captures();
            last_seq   = '0;
            seq_valid  = 1'b0;
            lost_total = '0;
            mismatches = 0;
            expected_verdicts.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_EXPECTED_MAGIC)
                    magic_reg = cfg_data[31:0];
                else if (cfg_index == CFG_RAW_PCM_CODE)
                    pcm_reg = cfg_data[7:0];
            end

            // accepted request
            if (in_ch.valid && in_ch.ready)
            begin
                if (parse_request(in_ch.command, in_ch.data_byte, in_ch.last_byte, fresh))
                    expected_verdicts.push_back(fresh);
            end

            // accepted result
            if (out_ch.valid && out_ch.ready)
            begin
                got.verdict = out_ch.verdict;
                got.codec   = out_ch.codec_id;
                got.rate    = out_ch.sample_rate;
                got.chans   = out_ch.channel_count;
                got.len     = out_ch.payload_length;
                got.lost    = out_ch.lost_packets;
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result v=%0d codec=%h rate=%h ch=%h len=%h lost=%h",
                                 $realtime, got.verdict, got.codec, got.rate, got.chans,
                                 got.len, got.lost);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.verdict !== want.verdict || got.codec !== want.codec
                            || got.rate !== want.rate || got.chans !== want.chans
                            || got.len !== want.len || got.lost !== want.lost)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected v=%0d codec=%h rate=%h ch=%h len=%h lost=%h",
                                     $realtime, want.verdict, want.codec, want.rate,
                                     want.chans, want.len, want.lost);
                            $display("%0t: actual   v=%0d codec=%h rate=%h ch=%h len=%h lost=%h",
                                     $realtime, got.verdict, got.codec, got.rate,
                                     got.chans, got.len, got.lost);
                        end
                    end
                end
            end

            fail_count <= mismatches;
            pending    <= expected_verdicts.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// top of the datagram header parser testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import dhp_pkg::*;

    localparam int MAX_BYTES     = 1600;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;

    // request codes on the input channel
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int          in_idle_pct;
    int          out_idle_pct;
    int          items_sent;
    int unsigned cycle_count = 0;
    logic [31:0] cur_magic;
    logic [7:0]  cur_pcm;
    logic [15:0] seq_prev;
    byte_req_t   datagram_q[$];

    dhp_in_if  in_ch();
    dhp_out_if out_ch();

    datagram_header_parser_loss_counter #(.MAX_DATAGRAM(MAX_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    dhp_verdict_checker #(.MAX_BYTES(MAX_BYTES)) verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("datagram_header_parser_loss_counter: mismatch");
            $finish;
        end
    end

    task automatic write_config(input logic [31:0] magic, input logic [7:0] pcm);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_MAGIC;
        cfg_data  <= magic;
        @(posedge clk);
        cfg_index <= CFG_RAW_PCM_CODE;
        cfg_data  <= {24'd0, pcm};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_magic = magic;
        cur_pcm   = pcm;
    endtask

    task automatic add_restart();
        datagram_q.push_back('{command: CMD_RESTART, data_byte: 8'($urandom),
                               last_byte: 1'($urandom)});
    endtask

    // queue one datagram, optionally with a restart before byte restart_at
    task automatic add_datagram(input logic [31:0] magic, input logic [7:0] codec,
                                input logic [23:0] rate, input logic [7:0] chans,
                                input logic [15:0] len, input logic [15:0] seq,
                                input int total, input int restart_at);
        logic [103:0] header;
        logic [7:0]   b;
        header = {seq, len, chans, rate, codec, magic};
        for (int i = 0; i < total; i++)
        begin
            if (i == restart_at)
                add_restart();
            b = (i < SEQUENCE_END) ? header[8*i +: 8] : 8'($urandom);
            datagram_q.push_back('{command: CMD_DATA, data_byte: b,
                                   last_byte: (i == total - 1)});
        end
    endtask

    function automatic logic [15:0] next_sequence();
        logic [15:0] s;
        case ($urandom_range(3))
            0:       s = seq_prev;
            1:       s = seq_prev + 16'd1;
            2:       s = seq_prev + 16'($urandom_range(2, 10));
            default: s = 16'($urandom);
        endcase
        seq_prev = s;
        return s;
    endfunction

    // half well-formed raw pcm, the rest malformed or noise
    task automatic add_random_datagram();
        int          kind;
        int          total;
        int          restart_at;
        logic [31:0] magic;
        logic [7:0]  codec;
        logic [15:0] len;
        logic [15:0] seq;
        kind  = $urandom_range(99);
        magic = cur_magic;
        codec = cur_pcm;
        seq   = 16'($urandom);
        if (kind < 50)
        begin
            len   = ($urandom_range(19) == 0) ? 16'($urandom_range(2, 200))
                                              : 16'($urandom_range(2, 6));
            seq   = next_sequence();
            total = HEADER_BYTES + int'(len)
                    + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
        end
        else if (kind < 60)
        begin
            if ($urandom_range(1) == 0)
            begin
                codec = cur_pcm ^ 8'($urandom_range(1, 255));
                len   = 16'($urandom_range(0, 8));
            end
            else
                len = 16'($urandom_range(0, 1));
            total = HEADER_BYTES + int'(len);
        end
        else if (kind < 70)
        begin
            len   = 16'($urandom);
            total = $urandom_range(1, HEADER_BYTES - 1);
        end
        else if (kind < 80)
        begin
            magic = cur_magic ^ (32'd1 << $urandom_range(31));
            len   = 16'($urandom_range(0, 8));
            total = HEADER_BYTES + int'(len);
        end
        else if (kind < 90)
        begin
            len   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20));
            total = $urandom_range(HEADER_BYTES, HEADER_BYTES + 20);
            if (total >= HEADER_BYTES + int'(len))
                total = HEADER_BYTES + int'(len) - 1;
        end
        else
        begin
            magic = $urandom;
            codec = 8'($urandom);
            len   = 16'($urandom);
            total = $urandom_range(1, 30);
        end
        restart_at = ($urandom_range(9) == 0) ? $urandom_range(0, total - 1) : -1;
        if ($urandom_range(11) == 0)
            add_restart();
        add_datagram(magic, codec, 24'($urandom), 8'($urandom), len, seq, total, restart_at);
    endtask

    task automatic send_request(input byte_req_t r);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= r.command;
        in_ch.data_byte <= r.data_byte;
        in_ch.last_byte <= r.last_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_datagrams();
        while (datagram_q.size() > 0)
            send_request(datagram_q.pop_front());
    endtask

    // hold the sender until every result is back and the pipeline is empty
    task automatic wait_results_settled();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          phase_start;
        logic [31:0] magic;
        logic [7:0]  pcm;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_DATA;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        in_idle_pct     = 17;
        out_idle_pct    = 45;
        items_sent      = 0;
        cur_magic       = '0;
        cur_pcm         = '0;
        seq_prev        = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset register values
        add_datagram(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1, -1);
        add_datagram(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 10, -1);
        // first sequence, repeat, in order, forward gap, wrapped gap
        add_datagram(32'd0, 8'd0, 24'd48000, 8'd2, 16'd2, 16'h0005, 13, -1);
        add_datagram(32'd0, 8'd0, 24'd48000, 8'd2, 16'd2, 16'h0005, 13, -1);
        add_datagram(32'd0, 8'd0, 24'd48000, 8'd2, 16'd2, 16'h0006, 13, -1);
        add_datagram(32'd0, 8'd0, 24'd0, 8'd1, 16'd2, 16'h000A, 13, -1);
        add_datagram(32'd0, 8'd0, 24'd0, 8'd1, 16'd2, 16'h0003, 13, -1);
        // restart between datagrams and in the middle of one
        add_restart();
        add_datagram(32'd0, 8'd0, 24'd44100, 8'd2, 16'd4, 16'h1234, 15, 5);
        add_datagram(32'h0000_0100, 8'd0, 24'd8000, 8'd1, 16'd0, 16'h0000, 11, -1);
        add_datagram(32'd0, 8'd0, 24'd8000, 8'd1, 16'd8, 16'h1235, 14, -1);
        add_datagram(32'd0, 8'd1, 24'd8000, 8'd1, 16'd2, 16'h2000, 13, -1);
        add_datagram(32'd0, 8'd0, 24'd8000, 8'd1, 16'd1, 16'h3000, 12, -1);
        // oversize: bytes past the limit are dropped, the last mark still ends it
        add_datagram(32'd0, 8'd0, 24'd96000, 8'd8, 16'(MAX_BYTES - HEADER_BYTES),
                     16'h1236, MAX_BYTES + 3, -1);
        send_datagrams();
        wait_results_settled();

        // random phases over register settings and idle patterns
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                in_idle_pct  = 17;
                out_idle_pct = 45;
            end
            else if (p < 4)
            begin
                in_idle_pct  = 45;
                out_idle_pct = 17;
            end
            else
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            magic = (p == 0) ? 32'hFFFF_FFFF : (p == 3) ? 32'd0 : $urandom;
            pcm   = (p == 0) ? 8'hFF : (p == 3) ? 8'd0 : 8'($urandom);
            write_config(magic, pcm);
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / PHASES)
            begin
                add_random_datagram();
                send_datagrams();
            end
            wait_results_settled();
        end

        if (fail_count == 0)
            $display("datagram_header_parser_loss_counter: match");
        else
            $display("datagram_header_parser_loss_counter: mismatch");
        $finish;
    end

endmodule
